@@ src/mcsl_pkg.sv @@
// Package for the multi-code sequence lock: widths, code reset values,
// match codes and the result beat type. No dependencies.
package mcsl_pkg;

  localparam int CODE_COUNT = 8;
  localparam int DIGIT_W    = 3;
  localparam int CODE_W     = CODE_COUNT * DIGIT_W;
  localparam int MATCH_W    = 4;
  localparam int LED_W      = CODE_COUNT;
  localparam int IDX_W      = $clog2(CODE_COUNT);
  localparam int ADDR_W     = IDX_W + 2;
  localparam int DATA_W     = 32;

  localparam logic [CODE_W-1:0] BLANK_CODE = {CODE_W{1'b1}};

  localparam logic [MATCH_W-1:0] MATCH_BLANK = 4'd8;
  localparam logic [MATCH_W-1:0] MATCH_NONE  = 4'd9;

  localparam logic [CODE_COUNT-1:0][CODE_W-1:0] CODE_RESET = '{
    24'd3479608, 24'd10591877, 24'd7407037, 24'd13613546,
    24'd15669444, 24'd1382225, 24'd15033625, 24'd342391
  };

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic               display_update;
    logic [MATCH_W-1:0] matched_code;
    logic [LED_W-1:0]   led_pattern;
  } res_t;

endpackage

@@ src/mcsl_in_if.sv @@
// Input channel of the lock: one button digit per beat.
// Depends on mcsl_pkg.
interface mcsl_in_if;
  logic                        valid;
  logic                        ready;
  logic [mcsl_pkg::DIGIT_W-1:0] digit;

  modport source (output valid, output digit, input ready);
  modport sink   (input valid, input digit, output ready);
endinterface

@@ src/mcsl_out_if.sv @@
// Result channel of the lock: match report and LED pattern per beat.
// Depends on mcsl_pkg.
interface mcsl_out_if;
  logic                         valid;
  logic                         ready;
  logic                         display_update;
  logic [mcsl_pkg::MATCH_W-1:0] matched_code;
  logic [mcsl_pkg::LED_W-1:0]   led_pattern;

  modport source (output valid, output display_update, output matched_code,
                  output led_pattern, input ready);
  modport sink   (input valid, input display_update, input matched_code,
                  input led_pattern, output ready);
endinterface

@@ src/mcsl_out_buf.sv @@
// Two-entry result buffer: output register plus skid register.
// Depends on mcsl_pkg and mcsl_out_if.
module mcsl_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mcsl_pkg::res_t push_data,
  output logic           push_ready,
  mcsl_out_if.source     out_ch
);

  logic           out_valid_r;
  logic           skid_valid_r;
  mcsl_pkg::res_t out_data_r;
  mcsl_pkg::res_t skid_data_r;
  logic           pop;

  assign pop        = out_valid_r && out_ch.ready;
  assign push_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        // push is held off while the skid entry is full
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.display_update = out_data_r.display_update;
  assign out_ch.matched_code   = out_data_r.matched_code;
  assign out_ch.led_pattern    = out_data_r.led_pattern;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && skid_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("skid entry lost while stalled");

endmodule

@@ src/multi_code_sequence_lock_top.sv @@
// Top level of the multi-code sequence lock: digit history, eight code
// compares with blank code, APB code registers. Depends on mcsl_pkg,
// mcsl_in_if, mcsl_out_if and mcsl_out_buf.
//
//  channel  | dir | handshake          | beat content
//  ---------+-----+--------------------+-------------------------------------
//  in_ch    | in  | valid/ready        | digit (3b)
//  out_ch   | out | valid/ready        | display_update, matched_code, leds
//  cfg_*    | in  | APB, pready tied 1 | code_a..code_h at byte addr 4*i
//
// Each digit beat is processed in the cycle it is accepted: the shift into
// the history, eight parallel compares, the blank compare and the state
// update all settle before the next edge, so one beat per cycle is taken
// while in_ch.ready is high. Each result is registered in the output buffer.
// A two-entry output buffer lets one result wait while the next is taken;
// in_ch.ready drops only when both entries are full.
// Synchronous active-low reset clears history, found flags, blanking and
// loads the default codes.
module multi_code_sequence_lock_top (
  input  logic                          clk,
  input  logic                          rst_n,
  mcsl_in_if.sink                       in_ch,
  mcsl_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mcsl_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [mcsl_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [mcsl_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  // Code registers, one per secret code.
  mcsl_pkg::code_t codes_r [mcsl_pkg::CODE_COUNT];

  // Lock state. The LED register always equals the found flags (both set
  // the same bit on a match and are never cleared), so keep one register.
  mcsl_pkg::code_t                  hist_r;
  mcsl_pkg::code_t                  hist_nxt;
  logic [mcsl_pkg::LED_W-1:0]       found_r;
  logic [mcsl_pkg::LED_W-1:0]       found_nxt;
  logic                             blanked_r;
  logic                             blanked_nxt;

  mcsl_pkg::code_t                  hist_shift;
  logic [mcsl_pkg::CODE_COUNT-1:0]  hit;
  logic                             code_hit;
  logic                             blank_hit;
  logic [mcsl_pkg::MATCH_W-1:0]     match;
  mcsl_pkg::res_t                   res;

  logic in_fire;
  logic buf_ready;
  logic cfg_wr;
  logic [mcsl_pkg::IDX_W-1:0] cfg_idx;

  assign in_ch.ready = buf_ready;
  assign in_fire     = in_ch.valid && buf_ready;

  // ---------------------------------------------------------------------
  // Configuration port: write on the access phase, read any time.
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[mcsl_pkg::ADDR_W-1:2];
  assign cfg_prdata = {{(mcsl_pkg::DATA_W - mcsl_pkg::CODE_W){1'b0}}, codes_r[cfg_idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mcsl_pkg::CODE_COUNT; k++) begin
        codes_r[k] <= mcsl_pkg::CODE_RESET[k];
      end
    end else if (cfg_wr) begin
      codes_r[cfg_idx] <= cfg_pwdata[mcsl_pkg::CODE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Match logic: shift the digit in, compare all unfound codes at once,
  // then take the first hit in priority order (code a first).
  // ---------------------------------------------------------------------
  assign hist_shift = {hist_r[mcsl_pkg::CODE_W-mcsl_pkg::DIGIT_W-1:0], in_ch.digit};

  always_comb begin
    for (int k = 0; k < mcsl_pkg::CODE_COUNT; k++) begin
      // code k owns LED bit (CODE_COUNT-1-k)
      hit[k] = !found_r[mcsl_pkg::CODE_COUNT-1-k] && (hist_shift == codes_r[k]);
    end
  end

  always_comb begin
    found_nxt = found_r;
    match     = mcsl_pkg::MATCH_NONE;
    code_hit  = 1'b0;
    // walk from the lowest priority up so the earliest hit wins
    for (int k = mcsl_pkg::CODE_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        match    = k[mcsl_pkg::MATCH_W-1:0];
        code_hit = 1'b1;
      end
    end
    if (code_hit) begin
      found_nxt[mcsl_pkg::IDX_W'(mcsl_pkg::CODE_COUNT - 1) - match[mcsl_pkg::IDX_W-1:0]] = 1'b1;
    end
    blank_hit = !code_hit && (hist_shift == mcsl_pkg::BLANK_CODE);
    if (blank_hit) begin
      match = mcsl_pkg::MATCH_BLANK;
    end
    blanked_nxt = blanked_r ^ blank_hit;
    // any match restarts entry from an empty history
    hist_nxt    = (code_hit || blank_hit) ? '0 : hist_shift;

    res.display_update = code_hit || blank_hit;
    res.matched_code   = match;
    res.led_pattern    = blanked_nxt ? '0 : found_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r    <= '0;
      found_r   <= '0;
      blanked_r <= 1'b0;
    end else if (in_fire) begin
      hist_r    <= hist_nxt;
      found_r   <= found_nxt;
      blanked_r <= blanked_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result buffer
  // ---------------------------------------------------------------------
  mcsl_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_data  (res),
    .push_ready (buf_ready),
    .out_ch     (out_ch)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((found_r & $past(found_r)) == $past(found_r)))
    else $error("found flag cleared");

  a_one_found_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(found_nxt ^ found_r) <= 1)
    else $error("more than one code found on one digit");

  a_match_clears_history: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (code_hit || blank_hit)) |=> (hist_r == '0))
    else $error("history not cleared after a match");

  a_blank_only_without_code: assert property (@(posedge clk) disable iff (!rst_n)
    !(code_hit && blank_hit))
    else $error("code and blank matched together");

endmodule

@@ tb/tb_multi_code_sequence_lock_top.sv @@
// Testbench for multi_code_sequence_lock_top: drives digit beats, writes the code
// registers over APB between phases and checks every result beat against a lock model.
// Depends on mcsl_pkg, mcsl_in_if, mcsl_out_if and the RTL of the lock.
module tb_multi_code_sequence_lock_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Register map of the code store, one code per 32-bit word.
  typedef enum int {
    REG_CODE_A, REG_CODE_B, REG_CODE_C, REG_CODE_D,
    REG_CODE_E, REG_CODE_F, REG_CODE_G, REG_CODE_H
  } code_reg_e;

  localparam int    CODE_DIGITS    = mcsl_pkg::CODE_W / mcsl_pkg::DIGIT_W;
  localparam int    QUIET_LIMIT    = 1000;  // quiet stretch without any beat before giving up
  localparam int    SQUEEZE_CYCLES = 64;    // long receiver hold-off
  localparam int    PHASE_PRESSES  = 280;
  localparam int    RANDOM_PHASES  = 5;
  localparam mcsl_pkg::code_t DUP_CODE = 24'o71262431;

  logic clk = 1'b0;
  logic rst_n;

  mcsl_in_if  in_ch ();
  mcsl_out_if out_ch ();

  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [mcsl_pkg::ADDR_W-1:0] cfg_paddr;
  logic [mcsl_pkg::DATA_W-1:0] cfg_pwdata;
  logic [mcsl_pkg::DATA_W-1:0] cfg_prdata;
  logic                        cfg_pready;

  multi_code_sequence_lock_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Lock model: its own copy of the codes, the digit history and the flags.
  // The LED register always equals the found flags, so one vector serves both.
  // ---------------------------------------------------------------------------
  mcsl_pkg::code_t            lock_codes [mcsl_pkg::CODE_COUNT];
  mcsl_pkg::code_t            lock_history;
  logic [mcsl_pkg::LED_W-1:0] lock_found;
  logic                       lock_blanked;

  mcsl_pkg::res_t               expected_reports [$];
  logic [mcsl_pkg::DIGIT_W-1:0] press_queue [$];

  int presses_taken;
  int code_hits;
  int blank_hits;
  int cfg_writes;
  int mismatches;
  int results_seen;
  int squeeze_ask;

  // Shift one digit in, compare against unfound codes in priority order,
  // then against the blank code; any hit clears the history.
  function automatic mcsl_pkg::res_t press_digit(input logic [mcsl_pkg::DIGIT_W-1:0] d);
    mcsl_pkg::res_t               r;
    logic [mcsl_pkg::MATCH_W-1:0] hit;
    hit = mcsl_pkg::MATCH_NONE;
    lock_history = {lock_history[mcsl_pkg::CODE_W-mcsl_pkg::DIGIT_W-1:0], d};
    for (int k = 0; k < mcsl_pkg::CODE_COUNT; k++) begin
      if (hit == mcsl_pkg::MATCH_NONE && !lock_found[mcsl_pkg::LED_W-1-k] &&
          lock_history == lock_codes[k]) begin
        hit = mcsl_pkg::MATCH_W'(k);
        lock_found[mcsl_pkg::LED_W-1-k] = 1'b1;
      end
    end
    if (hit == mcsl_pkg::MATCH_NONE && lock_history == mcsl_pkg::BLANK_CODE) begin
      hit = mcsl_pkg::MATCH_BLANK;
      lock_blanked = ~lock_blanked;
    end
    if (hit != mcsl_pkg::MATCH_NONE) lock_history = '0;
    r.display_update = (hit != mcsl_pkg::MATCH_NONE);
    r.matched_code   = hit;
    r.led_pattern    = lock_blanked ? '0 : lock_found;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer queued digits, drawing a random idle gap after each beat.
  // Calm stretches with no gaps toggle in now and then.
  // ---------------------------------------------------------------------------
  int send_gap;
  bit send_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.digit <= '0;
      send_gap = 0;
      send_calm = 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // The offered beat is gone after this edge: idle, load the next or drop valid.
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (press_queue.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.digit <= press_queue.pop_front();
        if ($urandom_range(0, 63) == 0) send_calm = ~send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 4);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall for a random gap after each result beat, and hold off for a
  // long stretch on request so the output buffer fills and in_ch stalls.
  // ---------------------------------------------------------------------------
  int take_gap;
  bit take_calm;
  int squeeze_left;
  int squeeze_seen;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_gap = 0;
      take_calm = 1'b0;
      squeeze_left = 0;
      squeeze_seen = 0;
    end else begin
      if (squeeze_ask != squeeze_seen) begin
        squeeze_seen = squeeze_ask;
        squeeze_left = SQUEEZE_CYCLES;
      end
      if (out_ch.valid && out_ch.ready) begin
        if ($urandom_range(0, 63) == 0) take_calm = ~take_calm;
        take_gap = take_calm ? 0 : $urandom_range(0, 4);
      end
      if (squeeze_left > 0) begin
        squeeze_left--;
        out_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted digit beat, then check every accepted
  // result beat against the oldest prediction. Predict first so a result can
  // never be checked before its own digit is accounted for.
  // ---------------------------------------------------------------------------
  mcsl_pkg::res_t head_report;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      head_report = press_digit(in_ch.digit);
      expected_reports.push_back(head_report);
      presses_taken++;
      if (head_report.matched_code == mcsl_pkg::MATCH_BLANK) blank_hits++;
      else if (head_report.matched_code != mcsl_pkg::MATCH_NONE) code_hits++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: update=%0d code=%0d leds=%02h",
                   out_ch.display_update, out_ch.matched_code, out_ch.led_pattern);
      end else begin
        head_report = expected_reports.pop_front();
        if (out_ch.display_update !== head_report.display_update ||
            out_ch.matched_code   !== head_report.matched_code ||
            out_ch.led_pattern    !== head_report.led_pattern) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: expected update=%0d code=%0d leds=%02h, ",
                      "got update=%0d code=%0d leds=%02h"},
                     results_seen, head_report.display_update, head_report.matched_code,
                     head_report.led_pattern, out_ch.display_update, out_ch.matched_code,
                     out_ch.led_pattern);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count while nothing moves and end the run once the count reaches QUIET_LIMIT.
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || cfg_psel || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_reports.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue the first n digits of a code, oldest digit first.
  task automatic push_code(input mcsl_pkg::code_t c, input int n);
    for (int i = 0; i < n; i++)
      press_queue.push_back(c[mcsl_pkg::CODE_W-1-mcsl_pkg::DIGIT_W*i -: mcsl_pkg::DIGIT_W]);
  endtask

  // Write one code register: setup cycle, access cycle, and the write edge.
  // Junk in the upper data bits must be dropped by the block.
  task automatic write_code(input code_reg_e idx, input mcsl_pkg::code_t value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= mcsl_pkg::ADDR_W'(int'(idx) * 4);
    cfg_pwdata  <= {8'($urandom()), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    lock_codes[idx] = value;
    cfg_writes++;
    @(negedge clk);
  endtask

  // Hold until every queued digit is taken and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (press_queue.size() != 0 || in_ch.valid || expected_reports.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Mostly full code entries (with a little noise ahead), some cut-off
  // entries and some plain noise.
  task automatic queue_random_presses(input int n);
    int              start;
    int              kind;
    int              pick;
    mcsl_pkg::code_t target;
    start = press_queue.size();
    while (press_queue.size() - start < n) begin
      kind = $urandom_range(0, 9);
      pick = $urandom_range(0, mcsl_pkg::CODE_COUNT);
      target = (pick == mcsl_pkg::CODE_COUNT) ? mcsl_pkg::BLANK_CODE : lock_codes[pick];
      if (kind <= 5) begin
        repeat ($urandom_range(0, 3))
          press_queue.push_back(mcsl_pkg::DIGIT_W'($urandom()));
        push_code(target, CODE_DIGITS);
      end else if (kind <= 7) begin
        push_code(target, $urandom_range(1, CODE_DIGITS - 1));
      end else begin
        repeat ($urandom_range(1, 6))
          press_queue.push_back(mcsl_pkg::DIGIT_W'($urandom()));
      end
    end
  endtask

  // Pick a code value: the extremes, a copy of another code, or random.
  function automatic mcsl_pkg::code_t pick_code_value();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return mcsl_pkg::BLANK_CODE;
      2:       return lock_codes[$urandom_range(0, mcsl_pkg::CODE_COUNT - 1)];
      default: return mcsl_pkg::code_t'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before the first edge.
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.digit  = '0;
    out_ch.ready = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    for (int k = 0; k < mcsl_pkg::CODE_COUNT; k++) lock_codes[k] = mcsl_pkg::CODE_RESET[k];
    lock_history = '0;
    lock_found   = '0;
    lock_blanked = 1'b0;
    squeeze_ask  = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default codes: all sevens toggles blanking on, then code a is found
    // while the LEDs stay dark.
    push_code(mcsl_pkg::BLANK_CODE, CODE_DIGITS);
    push_code(lock_codes[REG_CODE_A], CODE_DIGITS);
    wait_drained();

    // Rewrite every register: code b all sevens so it beats the blank code,
    // codes c and d equal so only c hits first, code e all zeros.
    write_code(REG_CODE_A, mcsl_pkg::code_t'($urandom()));
    write_code(REG_CODE_B, mcsl_pkg::BLANK_CODE);
    write_code(REG_CODE_C, DUP_CODE);
    write_code(REG_CODE_D, DUP_CODE);
    write_code(REG_CODE_E, '0);
    write_code(REG_CODE_F, mcsl_pkg::code_t'($urandom()));
    write_code(REG_CODE_G, mcsl_pkg::code_t'($urandom()));
    write_code(REG_CODE_H, mcsl_pkg::code_t'($urandom()));
    push_code(mcsl_pkg::BLANK_CODE, CODE_DIGITS);
    push_code(DUP_CODE, CODE_DIGITS);
    wait_drained();

    // Random phases; the first one also squeezes the receiver so the output
    // buffer fills while digits keep coming.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase != 0) begin
        repeat ($urandom_range(1, 3))
          write_code(code_reg_e'($urandom_range(0, mcsl_pkg::CODE_COUNT - 1)),
                     pick_code_value());
      end
      queue_random_presses(PHASE_PRESSES);
      if (phase == 0) squeeze_ask++;
      wait_drained();
    end

    repeat (8) @(negedge clk);

    $display("covered %0d digit beats: %0d code matches, %0d blank toggles, %0d reg writes",
             presses_taken, code_hits, blank_hits, cfg_writes);
    $display("final found flags %b, blanked %0d, %0d mismatches",
             lock_found, lock_blanked, mismatches);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/mcsl_pkg.sv
src/mcsl_in_if.sv
src/mcsl_out_if.sv
src/mcsl_out_buf.sv
src/multi_code_sequence_lock_top.sv
tb/tb_multi_code_sequence_lock_top.sv
